/* src/cdfuv_pkg.sv */
// Shared constants and types for the cube direction to face/UV block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package cdfuv_pkg;

  // Default widths of the direction components and the face coordinates
  localparam int unsigned CoordWidthDef = 16;
  localparam int unsigned UvWidthDef    = 16;

  // Face codes
  localparam logic [2:0] FACE_POS_X = 3'd0;
  localparam logic [2:0] FACE_NEG_X = 3'd1;
  localparam logic [2:0] FACE_POS_Y = 3'd2;
  localparam logic [2:0] FACE_NEG_Y = 3'd3;
  localparam logic [2:0] FACE_POS_Z = 3'd4;
  localparam logic [2:0] FACE_NEG_Z = 3'd5;

  // Per-item control that rides along the divider chain
  typedef struct packed {
    logic       valid;
    logic [2:0] face;
    logic       zero;   // all components zero
    logic       sat_u;  // u numerator equals full scale
    logic       sat_v;  // v numerator equals full scale
  } ctrl_t;

endpackage

/* src/cdfuv_select.sv */
// Front stage: major axis and face selection, numerator/denominator setup.
// Depends on cdfuv_pkg.
`timescale 1ns / 1ps

module cdfuv_select #(
  parameter int unsigned COORD_WIDTH = cdfuv_pkg::CoordWidthDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [COORD_WIDTH-1:0]   dir_x_i,
  input  logic [COORD_WIDTH-1:0]   dir_y_i,
  input  logic [COORD_WIDTH-1:0]   dir_z_i,
  output cdfuv_pkg::ctrl_t         ctrl_o,
  output logic [COORD_WIDTH:0]     den_o,
  output logic [COORD_WIDTH+1:0]   rem_u_o,
  output logic [COORD_WIDTH+1:0]   rem_v_o
);
  import cdfuv_pkg::*;

  localparam int unsigned MW = COORD_WIDTH + 1;  // magnitude / numerator width
  localparam int unsigned RW = COORD_WIDTH + 2;  // remainder width

  logic signed [MW-1:0] xs, ys, zs;
  logic        [MW-1:0] ax, ay, az, m;
  logic signed [MW-1:0] nu, nv;
  logic        [2:0]    face;
  logic                 x_major, y_major;
  logic signed [RW-1:0] sum_u, sum_v;
  logic        [RW-1:0] den_ext;

  ctrl_t               ctrl_d, ctrl_q;
  logic [MW-1:0]       den_d, den_q;
  logic [RW-1:0]       rem_u_d, rem_u_q, rem_v_d, rem_v_q;

  // Sign-extend and take magnitudes; the most negative value stays exact
  always_comb begin
    xs = {dir_x_i[COORD_WIDTH-1], dir_x_i};
    ys = {dir_y_i[COORD_WIDTH-1], dir_y_i};
    zs = {dir_z_i[COORD_WIDTH-1], dir_z_i};
    ax = xs[MW-1] ? MW'(-xs) : MW'(xs);
    ay = ys[MW-1] ? MW'(-ys) : MW'(ys);
    az = zs[MW-1] ? MW'(-zs) : MW'(zs);
  end

  // Major axis: ties go to x, then y; zero major counts as positive
  always_comb begin
    x_major = (ax >= ay) && (ax >= az);
    y_major = (ay >= az);
    if (x_major) begin
      m    = ax;
      face = xs[MW-1] ? FACE_NEG_X : FACE_POS_X;
      nu   = xs[MW-1] ? zs : -zs;
      nv   = ys;
    end else if (y_major) begin
      m    = ay;
      face = ys[MW-1] ? FACE_NEG_Y : FACE_POS_Y;
      nu   = xs;
      nv   = ys[MW-1] ? zs : -zs;
    end else begin
      m    = az;
      face = zs[MW-1] ? FACE_NEG_Z : FACE_POS_Z;
      nu   = zs[MW-1] ? -xs : xs;
      nv   = ys;
    end
  end

  // Numerators shifted into [0, 2m], denominator 2m
  always_comb begin
    sum_u   = $signed({nu[MW-1], nu}) + $signed({1'b0, m});
    sum_v   = $signed({nv[MW-1], nv}) + $signed({1'b0, m});
    den_d   = {m[MW-2:0], 1'b0};
    den_ext = {1'b0, den_d};
    rem_u_d = RW'(sum_u);
    rem_v_d = RW'(sum_v);

    ctrl_d.valid = start_i;
    ctrl_d.face  = face;
    ctrl_d.zero  = (m == '0);
    ctrl_d.sat_u = (m != '0) && (rem_u_d == den_ext);
    ctrl_d.sat_v = (m != '0) && (rem_v_d == den_ext);
  end

  // Control register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    den_q   <= den_d;
    rem_u_q <= rem_u_d;
    rem_v_q <= rem_v_d;
  end

  assign ctrl_o  = ctrl_q;
  assign den_o   = den_q;
  assign rem_u_o = rem_u_q;
  assign rem_v_o = rem_v_q;

endmodule

/* src/cdfuv_div_cell.sv */
// One cell of the restoring divider chain: one quotient bit for u and v.
// Depends on cdfuv_pkg.
`timescale 1ns / 1ps

module cdfuv_div_cell #(
  parameter int unsigned COORD_WIDTH = cdfuv_pkg::CoordWidthDef,
  parameter int unsigned UV_WIDTH    = cdfuv_pkg::UvWidthDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cdfuv_pkg::ctrl_t         ctrl_i,
  input  logic [COORD_WIDTH:0]     den_i,
  input  logic [COORD_WIDTH+1:0]   rem_u_i,
  input  logic [COORD_WIDTH+1:0]   rem_v_i,
  input  logic [UV_WIDTH-1:0]      quo_u_i,
  input  logic [UV_WIDTH-1:0]      quo_v_i,
  output cdfuv_pkg::ctrl_t         ctrl_o,
  output logic [COORD_WIDTH:0]     den_o,
  output logic [COORD_WIDTH+1:0]   rem_u_o,
  output logic [COORD_WIDTH+1:0]   rem_v_o,
  output logic [UV_WIDTH-1:0]      quo_u_o,
  output logic [UV_WIDTH-1:0]      quo_v_o
);
  import cdfuv_pkg::*;

  localparam int unsigned RW = COORD_WIDTH + 2;

  logic [RW-1:0]       den_ext, sh_u, sh_v;
  logic                ge_u, ge_v;

  ctrl_t               ctrl_q;
  logic [COORD_WIDTH:0] den_q;
  logic [RW-1:0]       rem_u_d, rem_u_q, rem_v_d, rem_v_q;
  logic [UV_WIDTH-1:0] quo_u_d, quo_u_q, quo_v_d, quo_v_q;

  // Shift, compare against the divisor, subtract when it fits
  always_comb begin
    den_ext = {1'b0, den_i};
    sh_u    = {rem_u_i[RW-2:0], 1'b0};
    sh_v    = {rem_v_i[RW-2:0], 1'b0};
    ge_u    = (sh_u >= den_ext);
    ge_v    = (sh_v >= den_ext);
    rem_u_d = ge_u ? (sh_u - den_ext) : sh_u;
    rem_v_d = ge_v ? (sh_v - den_ext) : sh_v;
    quo_u_d = {quo_u_i[UV_WIDTH-2:0], ge_u};
    quo_v_d = {quo_v_i[UV_WIDTH-2:0], ge_v};
  end

  // Control register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_i;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    den_q   <= den_i;
    rem_u_q <= rem_u_d;
    rem_v_q <= rem_v_d;
    quo_u_q <= quo_u_d;
    quo_v_q <= quo_v_d;
  end

  assign ctrl_o  = ctrl_q;
  assign den_o   = den_q;
  assign rem_u_o = rem_u_q;
  assign rem_v_o = rem_v_q;
  assign quo_u_o = quo_u_q;
  assign quo_v_o = quo_v_q;

endmodule

/* src/cube_direction_to_face_uv.sv */
// Top level: cube-map face selection and face UV, fully pipelined.
// Depends on cdfuv_pkg, cdfuv_select and cdfuv_div_cell.
`timescale 1ns / 1ps

// One direction is taken every clock cycle; busy is always low and the
// receiver cannot stall. Each item's result is strobed on valid_o for one
// cycle, and the receiver takes it during that strobe. The result passes
// through one register for face selection, one divider cell per bit of the
// face coordinates (UV_WIDTH cells in a row, each producing one quotient
// bit of u and v), and one output register. Results leave in the order
// the items came in.

module cube_direction_to_face_uv #(
  parameter int unsigned COORD_WIDTH = cdfuv_pkg::CoordWidthDef,
  parameter int unsigned UV_WIDTH    = cdfuv_pkg::UvWidthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [COORD_WIDTH-1:0] dir_x_i,
  input  logic [COORD_WIDTH-1:0] dir_y_i,
  input  logic [COORD_WIDTH-1:0] dir_z_i,
  output logic                   valid_o,
  output logic [2:0]             face_o,
  output logic [UV_WIDTH-1:0]    coord_u_o,
  output logic [UV_WIDTH-1:0]    coord_v_o,
  output logic                   zero_vector_o
);
  import cdfuv_pkg::*;

  localparam int unsigned RW = COORD_WIDTH + 2;

  ctrl_t                ctrl_c  [UV_WIDTH+1];
  logic [COORD_WIDTH:0] den_c   [UV_WIDTH+1];
  logic [RW-1:0]        rem_u_c [UV_WIDTH+1];
  logic [RW-1:0]        rem_v_c [UV_WIDTH+1];
  logic [UV_WIDTH-1:0]  quo_u_c [UV_WIDTH+1];
  logic [UV_WIDTH-1:0]  quo_v_c [UV_WIDTH+1];

  logic                valid_q;
  logic [2:0]          face_d, face_q;
  logic [UV_WIDTH-1:0] u_d, u_q, v_d, v_q;
  logic                zero_q;

  // Never holds off the sender
  assign busy = 1'b0;

  // Face selection and divider setup
  cdfuv_select #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_select (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .dir_x_i (dir_x_i),
    .dir_y_i (dir_y_i),
    .dir_z_i (dir_z_i),
    .ctrl_o  (ctrl_c[0]),
    .den_o   (den_c[0]),
    .rem_u_o (rem_u_c[0]),
    .rem_v_o (rem_v_c[0])
  );

  assign quo_u_c[0] = '0;
  assign quo_v_c[0] = '0;

  // Divider chain, one quotient bit per cell
  for (genvar i = 0; i < UV_WIDTH; i++) begin : g_cell
    cdfuv_div_cell #(
      .COORD_WIDTH (COORD_WIDTH),
      .UV_WIDTH    (UV_WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl_c[i]),
      .den_i   (den_c[i]),
      .rem_u_i (rem_u_c[i]),
      .rem_v_i (rem_v_c[i]),
      .quo_u_i (quo_u_c[i]),
      .quo_v_i (quo_v_c[i]),
      .ctrl_o  (ctrl_c[i+1]),
      .den_o   (den_c[i+1]),
      .rem_u_o (rem_u_c[i+1]),
      .rem_v_o (rem_v_c[i+1]),
      .quo_u_o (quo_u_c[i+1]),
      .quo_v_o (quo_v_c[i+1])
    );
  end

  // Final fix-up: zero vector clears, full scale saturates
  always_comb begin
    face_d = ctrl_c[UV_WIDTH].face;
    if (ctrl_c[UV_WIDTH].zero) begin
      u_d = '0;
      v_d = '0;
    end else begin
      u_d = ctrl_c[UV_WIDTH].sat_u ? '1 : quo_u_c[UV_WIDTH];
      v_d = ctrl_c[UV_WIDTH].sat_v ? '1 : quo_v_c[UV_WIDTH];
    end
  end

  // Output strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctrl_c[UV_WIDTH].valid;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    face_q <= face_d;
    u_q    <= u_d;
    v_q    <= v_d;
    zero_q <= ctrl_c[UV_WIDTH].zero;
  end

  assign valid_o       = valid_q;
  assign face_o        = face_q;
  assign coord_u_o     = u_q;
  assign coord_v_o     = v_q;
  assign zero_vector_o = zero_q;

endmodule

/* test/testbench.sv */
// Testbench for cube_direction_to_face_uv: directed table plus random directions,
// each result checked field by field against a typed-in value or a behavioral face/UV predictor.
// Depends on cdfuv_pkg and the RTL of cube_direction_to_face_uv.
`timescale 1ns / 1ps

module testbench;
  import cdfuv_pkg::*;

  localparam int unsigned CW = CoordWidthDef;
  localparam int unsigned UW = UvWidthDef;
  localparam longint UV_MAX = (longint'(1) << UW) - 1;
  localparam int NUM_PROBES = 22;

  // One direction as driven on the ports (two's complement)
  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] z;
  } dir_t;

  // One face lookup result
  typedef struct packed {
    logic [2:0]    face;
    logic [UW-1:0] u;
    logic [UW-1:0] v;
    logic          zero;
  } face_uv_t;

  // Directed row: result typed in only where it is obvious
  typedef struct packed {
    dir_t     dir;
    logic     typed;
    face_uv_t want;
  } probe_row_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  logic [CW-1:0] dir_x_i = '0;
  logic [CW-1:0] dir_y_i = '0;
  logic [CW-1:0] dir_z_i = '0;
  logic          valid_o;
  logic [2:0]    face_o;
  logic [UW-1:0] coord_u_o;
  logic [UW-1:0] coord_v_o;
  logic          zero_vector_o;

  face_uv_t pending_lookups[$];
  int       mismatch_count = 0;

  probe_row_t probe_table [NUM_PROBES] = '{
    // zero vector
    '{'{0, 0, 0}, 1'b1, '{FACE_POS_X, 16'd0, 16'd0, 1'b1}},
    // each face at full scale, minors zero -> center of the face
    '{'{32767, 0, 0}, 1'b1, '{FACE_POS_X, 16'd32768, 16'd32768, 1'b0}},
    '{'{-32768, 0, 0}, 1'b1, '{FACE_NEG_X, 16'd32768, 16'd32768, 1'b0}},
    '{'{0, 32767, 0}, 1'b1, '{FACE_POS_Y, 16'd32768, 16'd32768, 1'b0}},
    '{'{0, -32768, 0}, 1'b1, '{FACE_NEG_Y, 16'd32768, 16'd32768, 1'b0}},
    '{'{0, 0, 32767}, 1'b1, '{FACE_POS_Z, 16'd32768, 16'd32768, 1'b0}},
    '{'{0, 0, -32768}, 1'b1, '{FACE_NEG_Z, 16'd32768, 16'd32768, 1'b0}},
    // three-way ties go to x; full-scale minor saturates
    '{'{100, 100, 100}, 1'b1, '{FACE_POS_X, 16'd0, 16'd65535, 1'b0}},
    '{'{-100, -100, -100}, 1'b1, '{FACE_NEG_X, 16'd0, 16'd0, 1'b0}},
    // y beats z on a tie
    '{'{0, 5, 5}, 1'b1, '{FACE_POS_Y, 16'd32768, 16'd0, 1'b0}},
    // most negative and largest inputs
    '{'{-32768, -32768, -32768}, 1'b1, '{FACE_NEG_X, 16'd0, 16'd0, 1'b0}},
    '{'{-32768, 32767, -32767}, 1'b1, '{FACE_NEG_X, 16'd1, 16'd65535, 1'b0}},
    '{'{32767, -32767, 32767}, 1'b1, '{FACE_POS_X, 16'd0, 16'd0, 1'b0}},
    // smallest nonzero vectors
    '{'{1, 0, 0}, 1'b1, '{FACE_POS_X, 16'd32768, 16'd32768, 1'b0}},
    '{'{0, 0, -1}, 1'b1, '{FACE_NEG_Z, 16'd32768, 16'd32768, 1'b0}},
    // the rest go through the predictor
    '{'{3, -7, 2}, 1'b0, '0},
    '{'{-12345, 20000, 31000}, 1'b0, '0},
    '{'{1, 1, -2}, 1'b0, '0},
    '{'{0, -1, 1}, 1'b0, '0},
    '{'{-5, 3, -4}, 1'b0, '0},
    '{'{32767, 32767, -32768}, 1'b0, '0},
    '{'{-1, -1, 0}, 1'b0, '0}
  };

  cube_direction_to_face_uv dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .dir_x_i       (dir_x_i),
    .dir_y_i       (dir_y_i),
    .dir_z_i       (dir_z_i),
    .valid_o       (valid_o),
    .face_o        (face_o),
    .coord_u_o     (coord_u_o),
    .coord_v_o     (coord_v_o),
    .zero_vector_o (zero_vector_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // floor((n + m) * 2^UW / 2m), clipped to all ones at n == m
  function automatic logic [UW-1:0] uv_fraction(input longint n, input longint m);
    longint q;
    q = ((n + m) <<< UW) / (2 * m);
    return (q > UV_MAX) ? UV_MAX[UW-1:0] : q[UW-1:0];
  endfunction

  // Face pick and face coordinates for one direction
  function automatic face_uv_t predict_face_uv(input dir_t d);
    longint   x, y, z, ax, ay, az, m, nu, nv;
    face_uv_t r;
    x = longint'($signed(d.x));
    y = longint'($signed(d.y));
    z = longint'($signed(d.z));
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    az = (z < 0) ? -z : z;
    r = '0;
    if (ax == 0 && ay == 0 && az == 0) begin
      r.face = FACE_POS_X;
      r.zero = 1'b1;
      return r;
    end
    if (ax >= ay && ax >= az) begin
      r.face = (x >= 0) ? FACE_POS_X : FACE_NEG_X;
      m  = ax;
      nu = (x >= 0) ? -z : z;
      nv = y;
    end else if (ay >= az) begin
      r.face = (y >= 0) ? FACE_POS_Y : FACE_NEG_Y;
      m  = ay;
      nu = x;
      nv = (y >= 0) ? -z : z;
    end else begin
      r.face = (z >= 0) ? FACE_POS_Z : FACE_NEG_Z;
      m  = az;
      nu = (z >= 0) ? x : -x;
      nv = y;
    end
    r.u = uv_fraction(nu, m);
    r.v = uv_fraction(nv, m);
    return r;
  endfunction

  // Random direction: mostly full range, plus tiny vectors, ties and
  // full-scale minors, and the odd zero vector
  function automatic dir_t rand_direction();
    dir_t          d;
    logic [CW-1:0] a;
    int            kind;
    kind = $urandom_range(0, 19);
    a    = CW'($urandom);
    d.x  = CW'($urandom);
    d.y  = CW'($urandom);
    d.z  = CW'($urandom);
    if (kind == 0) begin
      d = '0;
    end else if (kind < 5) begin
      d.x = CW'($urandom_range(0, 6) - 3);
      d.y = CW'($urandom_range(0, 6) - 3);
      d.z = CW'($urandom_range(0, 6) - 3);
    end else if (kind < 10) begin
      d.x = $urandom_range(1) ? a : -a;
      d.y = $urandom_range(1) ? a : -a;
      d.z = $urandom_range(1) ? a : -a;
      case ($urandom_range(0, 3))
        0: d.x = CW'($urandom);
        1: d.y = CW'($urandom);
        2: d.z = CW'($urandom);
        default: ;
      endcase
    end
    return d;
  endfunction

  // Present one item, hold it until taken, then idle cycle by cycle
  task automatic issue_direction(input dir_t d, input face_uv_t want, input int idle_pct);
    start   <= 1'b1;
    dir_x_i <= d.x;
    dir_y_i <= d.y;
    dir_z_i <= d.z;
    do @(posedge clk_i); while (busy);
    pending_lookups.push_back(want);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Result checker
  always @(posedge clk_i) begin
    face_uv_t want;
    if (rst_ni && valid_o) begin
      if (pending_lookups.size() == 0) begin
        $error("result with none expected: face %0d u %0d v %0d zero %0b",
               face_o, coord_u_o, coord_v_o, zero_vector_o);
        mismatch_count++;
      end else begin
        want = pending_lookups.pop_front();
        if (face_o !== want.face) begin
          $error("face: expected %0d, got %0d", want.face, face_o);
          mismatch_count++;
        end
        if (coord_u_o !== want.u) begin
          $error("coord_u: expected %0d, got %0d", want.u, coord_u_o);
          mismatch_count++;
        end
        if (coord_v_o !== want.v) begin
          $error("coord_v: expected %0d, got %0d", want.v, coord_v_o);
          mismatch_count++;
        end
        if (zero_vector_o !== want.zero) begin
          $error("zero_vector: expected %0b, got %0b", want.zero, zero_vector_o);
          mismatch_count++;
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    dir_t d;
    int   idle_pct;
    int   drain_cycles;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (int i = 0; i < NUM_PROBES; i++) begin
      issue_direction(probe_table[i].dir,
                      probe_table[i].typed ? probe_table[i].want
                                           : predict_face_uv(probe_table[i].dir), 0);
    end

    // random items in three idling phases
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 37 : (ph == 1) ? 57 : 0;
      repeat (134) begin
        d = rand_direction();
        issue_direction(d, predict_face_uv(d), idle_pct);
      end
    end
    start <= 1'b0;

    // drain the pipeline
    drain_cycles = 0;
    while (pending_lookups.size() != 0 && drain_cycles < 1000) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    repeat (UW + 4) @(posedge clk_i);
    if (pending_lookups.size() != 0)
      $error("%0d results never arrived", pending_lookups.size());
    if (mismatch_count == 0 && pending_lookups.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

/* files.f */
src/cdfuv_pkg.sv
src/cdfuv_select.sv
src/cdfuv_div_cell.sv
src/cube_direction_to_face_uv.sv
test/testbench.sv
